FILE: src/sph_pressure_acceleration_sum_macros.svh
// Assertion macros for the SPH pressure acceleration block.
`ifndef SPH_PRESSURE_ACCELERATION_SUM_MACROS_SVH
`define SPH_PRESSURE_ACCELERATION_SUM_MACROS_SVH
`ifndef SYNTHESIS
`define SPA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SPA_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SPA_ASSERT(label, clk, rst_n, prop, msg)
`define SPA_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

FILE: src/spa_pkg.sv
// Shared types and constants for the SPH pressure acceleration block.
`timescale 1ns / 1ps
`default_nettype none
package spa_pkg;
  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned FracBitsDef   = 16;
  localparam int unsigned SumWidth      = 48;
  localparam int unsigned RhoWidth      = 31;
  localparam int unsigned PresWidth     = 32;
  localparam int unsigned GradWidth     = 32;
  localparam int unsigned OutWidth      = 32;
  localparam logic [RhoWidth-1:0] RestReset = 31'd65536000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_S, ST_DIV_N, ST_COEFF, ST_MASS, ST_K, ST_GX, ST_GY, ST_OUT
  } spa_state_e;

  typedef struct packed {
    logic load;       // capture input item
    logic div_start;  // start divider
    logic div_nbr;    // divide neighbour side (else self)
    logic do_coeff;
    logic do_mass;
    logic do_k;
    logic do_gx;
    logic do_gy;
    logic out_load;
    logic clear_sum;
  } spa_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
    logic solid;
    logic empty;
    logic last;
  } spa_stat_t;
endpackage
`default_nettype wire

FILE: src/sph_pressure_acceleration_sum.sv
// Top level of the SPH pressure acceleration accumulator.
`timescale 1ns / 1ps
`default_nettype none
`include "sph_pressure_acceleration_sum_macros.svh"
// Accumulates -rest_density*volume*(p/rho^2 terms)*grad per neighbour term and
// emits the saturated 2D sum on the term marked last. One term at a time: each
// p/rho^2 division on the restoring divider has a start step, one quotient bit
// per cycle and a completion step. A fluid term needs two divisions plus the
// transfer, coefficient, mass, scale, x and y updates and the output step; a
// solid term needs one division, an empty term none. The result register lets
// the next term start while a result waits; a second last term stalls until it
// is taken.
module sph_pressure_acceleration_sum import spa_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [30:0] cfg_wdata_i,     // rest_density
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic        s_axis_tlast,    // last_term
  input  wire logic [1:0]  s_axis_tuser,    // solid_term, no_term
  // own_pressure, own_density, nbr_pressure, nbr_density, nbr_volume, grad_x, grad_y
  input  wire logic [223:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata     // accel_x, accel_y
);
  logic [RhoWidth-1:0] rest_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rest_q <= RestReset;
    else if (cfg_we_i) rest_q <= cfg_wdata_i;
  end

  spa_cmd_t  cmd;
  spa_stat_t stat;
  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  spa_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .in_ready_o(s_axis_tready),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .stat_i(stat), .cmd_o(cmd)
  );

  spa_datapath #(.VALUE_WIDTH(VALUE_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .rest_i(rest_q),
    .flags_i({s_axis_tlast, s_axis_tuser[1], s_axis_tuser[0]}),
    .sp_i(s_axis_tdata[31:0]), .sd_i(s_axis_tdata[62:32]),
    .np_i(s_axis_tdata[94:63]), .nd_i(s_axis_tdata[125:95]),
    .vol_i(s_axis_tdata[156:126]), .gx_i(s_axis_tdata[188:157]),
    .gy_i(s_axis_tdata[220:189]),
    .ax_o(m_axis_tdata[31:0]), .ay_o(m_axis_tdata[63:32])
  );

  `SPA_ASSERT(a_start_idle, clk_i, rst_ni, cmd.div_start |-> !stat.div_busy, "divider restart")
  `SPA_ASSERT_NEVER(a_gx_gy, clk_i, rst_ni, cmd.do_gx && cmd.do_gy, "both sums updated")
  `SPA_ASSERT(a_clear_out, clk_i, rst_ni, cmd.clear_sum |=> m_axis_tvalid, "cleared, no result")
endmodule
`default_nettype wire

FILE: src/spa_datapath.sv
// Datapath: operand registers, iterative divider, multiplier and sum registers.
`timescale 1ns / 1ps
`default_nettype none
module spa_datapath import spa_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = ValueWidthDef,
  parameter int unsigned FRAC_BITS   = FracBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire spa_cmd_t              cmd_i,
  output spa_stat_t                  stat_o,
  input  wire logic [RhoWidth-1:0]   rest_i,
  input  wire logic [2:0]            flags_i,
  input  wire logic [PresWidth-1:0]  sp_i,
  input  wire logic [RhoWidth-1:0]   sd_i,
  input  wire logic [PresWidth-1:0]  np_i,
  input  wire logic [RhoWidth-1:0]   nd_i,
  input  wire logic [RhoWidth-1:0]   vol_i,
  input  wire logic [GradWidth-1:0]  gx_i,
  input  wire logic [GradWidth-1:0]  gy_i,
  output logic [OutWidth-1:0]        ax_o,
  output logic [OutWidth-1:0]        ay_o
);
  localparam int unsigned DivSteps = 32 + 2 * FRAC_BITS;
  localparam int unsigned CntW = $clog2(DivSteps + 1);
  localparam int unsigned DenW = 2 * RhoWidth;
  localparam int unsigned DividW = PresWidth + 2 * FRAC_BITS;
  localparam int unsigned QW = VALUE_WIDTH + 1;
  localparam int unsigned MulW = (VALUE_WIDTH > GradWidth) ? VALUE_WIDTH : GradWidth;
  localparam logic [63:0] VMaxU = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] VLim  = 64'd1 << (VALUE_WIDTH - 1);
  localparam logic signed [63:0] SMax = (64'sd1 <<< (SumWidth - 1)) - 64'sd1;
  localparam logic signed [63:0] SMin = -(64'sd1 <<< (SumWidth - 1));

  logic [2:0] flags_q;
  logic [PresWidth-1:0] sp_q, np_q;
  logic [RhoWidth-1:0] sd_q, nd_q, vol_q;
  logic [GradWidth-1:0] gx_q, gy_q;
  logic signed [63:0] cs_q, cn_q, mass_q, k_q, coeff_q;
  logic signed [SumWidth-1:0] sx_q, sy_q;

  // Divider state.
  logic [DenW-1:0]   den_q;
  logic [DividW-1:0] dvd_q;
  logic [DenW:0]     rem_q;
  logic [QW-1:0]     quo_q;
  logic [CntW-1:0]   cnt_q;
  logic              busy_q, done_q, neg_q;

  function automatic logic signed [63:0] sat_v(input logic neg, input logic [63:0] mag);
    logic signed [63:0] r;
    if (neg) r = (mag >= VLim) ? -$signed(VLim) : -$signed(mag);
    else     r = (mag >= VLim) ? $signed(VMaxU) : $signed(mag);
    return r;
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? (~a + 64'd1) : a;
  endfunction

  // Fixed-point multiply. Every operand magnitude fits in MulW bits: values are
  // within VALUE_WIDTH signed bits, the register and volume within 31 bits and
  // the gradient within 32 signed bits.
  function automatic logic signed [63:0] mulq(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [MulW-1:0]   x, y;
    logic [2*MulW-1:0] p, q;
    logic neg;
    x = MulW'(mag64(a));
    y = MulW'(mag64(b));
    neg = a[63] ^ b[63];
    p = x * y;
    q = p >> FRAC_BITS;
    if (q == '0) return 64'sd0;
    if ((q >> (VALUE_WIDTH - 1)) != '0) return sat_v(neg, VLim);
    return sat_v(neg, 64'(q[VALUE_WIDTH-2:0]));
  endfunction

  function automatic logic signed [63:0] clamp_v(input logic signed [63:0] v);
    return sat_v(v[63], mag64(v));
  endfunction

  logic [DenW:0] rem_sh;
  logic [DenW:0] rem_sub;
  logic          ge;
  logic [QW-1:0] quo_n;

  always_comb begin
    rem_sh = {rem_q[DenW-1:0], dvd_q[DividW-1]};
    ge = rem_sh >= {1'b0, den_q};
    rem_sub = ge ? rem_sh - {1'b0, den_q} : rem_sh;
    quo_n = {quo_q[QW-2:0], ge};
    if (quo_q[QW-1] && (quo_q[QW-2:0] != '0)) quo_n = {1'b1, {(QW-1){1'b0}}};
    // Once above the cap, shifting keeps it capped.
    if ({quo_q, ge} > {1'b0, 1'b1, {(QW-1){1'b0}}}) quo_n = {1'b1, {(QW-1){1'b0}}};
  end

  logic [RhoWidth-1:0] dsel;
  logic [PresWidth-1:0] psel;
  assign dsel = cmd_i.div_nbr ? nd_q : sd_q;
  assign psel = cmd_i.div_nbr ? np_q : sp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.div_start) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  logic [63:0] qext;
  assign qext = 64'(quo_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      den_q <= {{RhoWidth{1'b0}}, dsel} * {{RhoWidth{1'b0}}, dsel};
      dvd_q <= {(psel[PresWidth-1] ? (~psel + 1'b1) : psel), {(2*FRAC_BITS){1'b0}}};
      rem_q <= '0;
      quo_q <= '0;
      neg_q <= psel[PresWidth-1];
    end else if (busy_q) begin
      rem_q <= rem_sub;
      quo_q <= quo_n;
      dvd_q <= {dvd_q[DividW-2:0], 1'b0};
    end
    if (done_q) begin
      logic signed [63:0] r;
      r = (den_q == '0 || quo_q == '0) ? 64'sd0 : sat_v(neg_q, qext);
      if (cmd_i.div_nbr) cn_q <= r;
      else               cs_q <= r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      flags_q <= flags_i;
      sp_q <= sp_i; sd_q <= sd_i; np_q <= np_i; nd_q <= nd_i;
      vol_q <= vol_i; gx_q <= gx_i; gy_q <= gy_i;
    end
    if (cmd_i.do_coeff)
      coeff_q <= flags_q[0] ? cs_q : clamp_v(cs_q + cn_q);
    if (cmd_i.do_mass)
      mass_q <= mulq(64'(rest_i), 64'(vol_q));
    if (cmd_i.do_k)
      k_q <= clamp_v(-mulq(mass_q, coeff_q));
  end

  logic signed [63:0] prod, sum_n;
  logic signed [SumWidth-1:0] sel_sum;
  assign sel_sum = cmd_i.do_gy ? sy_q : sx_q;
  always_comb begin
    prod = mulq(k_q, cmd_i.do_gy ? 64'($signed(gy_q)) : 64'($signed(gx_q)));
    sum_n = 64'(sel_sum) + prod;
    if (sum_n > SMax) sum_n = SMax;
    if (sum_n < SMin) sum_n = SMin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sx_q <= '0;
      sy_q <= '0;
    end else if (cmd_i.clear_sum) begin
      sx_q <= '0;
      sy_q <= '0;
    end else if (cmd_i.do_gx) begin
      sx_q <= sum_n[SumWidth-1:0];
    end else if (cmd_i.do_gy) begin
      sy_q <= sum_n[SumWidth-1:0];
    end
  end

  logic signed [63:0] cx, cy;
  assign cx = clamp_v(64'(sx_q));
  assign cy = clamp_v(64'(sy_q));
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      ax_o <= cx[OutWidth-1:0];
      ay_o <= cy[OutWidth-1:0];
    end
  end

  assign stat_o = '{div_busy: busy_q, div_done: done_q, solid: flags_q[0],
                    empty: flags_q[1], last: flags_q[2]};
endmodule
`default_nettype wire

FILE: src/spa_ctrl.sv
// Controller state machine sequencing one neighbour term.
`timescale 1ns / 1ps
`default_nettype none
module spa_ctrl import spa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_fire_i,
  output logic      in_ready_o,
  input  wire logic out_ready_i,
  output logic      out_valid_o,
  input  wire spa_stat_t stat_i,
  output spa_cmd_t  cmd_o
);
  spa_state_e state_q, state_d;
  logic ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q <= ov_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    ov_d = ov_q && !out_ready_i;
    in_ready_o = (state_q == ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_DIV_S;
        end
      end
      ST_DIV_S: begin
        if (stat_i.empty) begin
          state_d = ST_OUT;
        end else if (!stat_i.div_busy && !stat_i.div_done) begin
          cmd_o.div_start = 1'b1;
        end else if (stat_i.div_done) begin
          state_d = stat_i.solid ? ST_COEFF : ST_DIV_N;
        end
      end
      ST_DIV_N: begin
        cmd_o.div_nbr = 1'b1;
        if (!stat_i.div_busy && !stat_i.div_done) cmd_o.div_start = 1'b1;
        else if (stat_i.div_done) state_d = ST_COEFF;
      end
      ST_COEFF: begin cmd_o.do_coeff = 1'b1; state_d = ST_MASS; end
      ST_MASS:  begin cmd_o.do_mass = 1'b1; state_d = ST_K; end
      ST_K:     begin cmd_o.do_k = 1'b1; state_d = ST_GX; end
      ST_GX:    begin cmd_o.do_gx = 1'b1; state_d = ST_GY; end
      ST_GY:    begin cmd_o.do_gy = 1'b1; state_d = ST_OUT; end
      ST_OUT: begin
        if (!stat_i.last) begin
          state_d = ST_IDLE;
        end else if (!ov_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.clear_sum = 1'b1;
          ov_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    out_valid_o = ov_q;
  end
endmodule
`default_nettype wire

FILE: test/tb_sph_pressure_acceleration_sum.sv
// Self-checking testbench for the SPH pressure acceleration accumulator.
`timescale 1ns / 1ps
`default_nettype none
module tb_sph_pressure_acceleration_sum;
  import spa_pkg::*;

  typedef struct {
    bit        solid;
    bit        empty;
    bit        last;
    bit [31:0] self_p;
    bit [30:0] self_rho;
    bit [31:0] nbr_p;
    bit [30:0] nbr_rho;
    bit [30:0] nbr_vol;
    bit [31:0] grad_x;
    bit [31:0] grad_y;
  } term_t;

  typedef struct {
    bit [31:0] ax;
    bit [31:0] ay;
  } accel_t;

  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 400;
  localparam int unsigned StallLimit  = 20000;
  localparam int unsigned NumRandom   = 1250;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [30:0]  cfg_wdata_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic         s_axis_tlast;
  logic [1:0]   s_axis_tuser;    // solid_term, no_term
  // own_pressure, own_density, nbr_pressure, nbr_density, nbr_volume, grad_x, grad_y
  logic [223:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [63:0]  m_axis_tdata;    // accel_x, accel_y

  sph_pressure_acceleration_sum u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tlast (s_axis_tlast),
    .s_axis_tuser (s_axis_tuser),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  term_t  pending_terms[$];
  accel_t expected_accels[$];
  term_t  cur_term;
  bit     term_taken;
  int     send_idle_pct;
  int     recv_stall_pct;
  bit     hold_req;
  int     hold_cnt;
  int     mismatches;
  int     terms_seen;
  int     accels_seen;
  int     idle_cycles;

  // Predictor state.
  longint rest_rho;
  longint sum_x;
  longint sum_y;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic longint sat_to(longint v, int w);
    longint lim;
    lim = longint'(1) <<< (w - 1);
    if (v >= lim) return lim - 1;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [127:0] magnitude(longint a);
    return (a < 0) ? 128'(-a) : 128'(a);
  endfunction

  // Saturate a sign and magnitude to 32 signed bits; zero stays zero.
  function automatic longint sat_mag(bit neg, logic [127:0] q);
    if (q == 0) return 0;
    if (q >= 128'h8000_0000) return neg ? -longint'(32'h8000_0000) : 64'h7fff_ffff;
    return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  function automatic longint fixed_mul(longint a, longint b);
    logic [127:0] prod;
    prod = magnitude(a) * magnitude(b);
    return sat_mag((a < 0) != (b < 0), prod >> 16);
  endfunction

  function automatic longint pressure_ratio(longint p, bit [30:0] rho);
    logic [127:0] den;
    den = 128'(rho) * 128'(rho);
    if (den == 0) return 0;
    return sat_mag(p < 0, (magnitude(p) << 32) / den);
  endfunction

  function automatic void accumulate_term(term_t t);
    longint coeff, mass, k;
    accel_t a;
    if (!t.empty) begin
      coeff = pressure_ratio(longint'($signed(t.self_p)), t.self_rho);
      if (!t.solid)
        coeff = sat_to(coeff + pressure_ratio(longint'($signed(t.nbr_p)), t.nbr_rho), 32);
      mass  = fixed_mul(rest_rho, longint'(t.nbr_vol));
      k     = sat_to(-fixed_mul(mass, coeff), 32);
      sum_x = sat_to(sum_x + fixed_mul(k, longint'($signed(t.grad_x))), 48);
      sum_y = sat_to(sum_y + fixed_mul(k, longint'($signed(t.grad_y))), 48);
    end
    if (t.last) begin
      a.ax = 32'(sat_to(sum_x, 32));
      a.ay = 32'(sat_to(sum_y, 32));
      expected_accels.push_back(a);
      sum_x = 0;
      sum_y = 0;
    end
  endfunction

  task automatic report_mismatch(string what, bit [31:0] got, bit [31:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  // Driver: inputs change on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || term_taken)) begin
      if (pending_terms.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_term = pending_terms.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tlast  <= cur_term.last;
        s_axis_tuser  <= {cur_term.empty, cur_term.solid};
        s_axis_tdata  <= {3'b0, cur_term.grad_y, cur_term.grad_x, cur_term.nbr_vol,
                          cur_term.nbr_rho, cur_term.nbr_p, cur_term.self_rho,
                          cur_term.self_p};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure, including an occasional long hold-off.
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HoldCycles;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor and watchdog: sample on the rising edge.
  always @(posedge clk_i) begin
    accel_t want;
    term_taken = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        term_taken = 1'b1;
        terms_seen++;
        accumulate_term(cur_term);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        accels_seen++;
        if (expected_accels.size() == 0) begin
          report_mismatch("unexpected result accel_x", m_axis_tdata[31:0], 32'h0);
        end else begin
          want = expected_accels.pop_front();
          if (m_axis_tdata[31:0] !== want.ax)
            report_mismatch("accel_x", m_axis_tdata[31:0], want.ax);
          if (m_axis_tdata[63:32] !== want.ay)
            report_mismatch("accel_y", m_axis_tdata[63:32], want.ay);
        end
      end
      if (term_taken || (m_axis_tvalid && m_axis_tready) ||
          (pending_terms.size() == 0 && expected_accels.size() == 0 && !s_axis_tvalid))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("no transfer for %0d cycles", StallLimit);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  function automatic bit [31:0] pick_signed();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'hffff_ffff;
      4, 5: return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
      default: return $urandom;
    endcase
  endfunction

  function automatic bit [30:0] pick_density();
    case ($urandom_range(7))
      0: return 31'h0;
      1: return 31'h7fff_ffff;
      2: return 31'd1;
      3, 4, 5: return 31'(65536000 + $urandom_range(0, 1 << 22) - (1 << 21));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic bit [30:0] pick_volume();
    case ($urandom_range(5))
      0: return 31'h0;
      1: return 31'h7fff_ffff;
      2, 3: return 31'($urandom_range(0, 1 << 10));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic term_t random_term(bit last);
    term_t t;
    t.solid    = $urandom_range(3) == 0;
    t.empty    = 1'b0;
    t.last     = last;
    t.self_p   = pick_signed();
    t.self_rho = pick_density();
    t.nbr_p    = pick_signed();
    t.nbr_rho  = pick_density();
    t.nbr_vol  = pick_volume();
    t.grad_x   = pick_signed();
    t.grad_y   = pick_signed();
    return t;
  endfunction

  function automatic term_t empty_term(bit last);
    term_t t;
    t = random_term(last);
    t.empty = 1'b1;
    return t;
  endfunction

  task automatic queue_particles(int count);
    int n, len;
    term_t t;
    n = 0;
    while (n < count) begin
      if ($urandom_range(9) == 0) begin
        // Noise: an empty item in mid-particle or an empty particle.
        pending_terms.push_back(empty_term(1'($urandom_range(1))));
        n++;
      end else begin
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          t = random_term(i == len - 1);
          if (i == len - 1 && $urandom_range(4) == 0) t = empty_term(1'b1);
          pending_terms.push_back(t);
          n++;
        end
      end
    end
  endtask

  task automatic drain();
    while (pending_terms.size() > 0 || s_axis_tvalid || expected_accels.size() > 0)
      @(posedge clk_i);
    // Empty items give no result but may still be in flight.
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_rest_density(bit [30:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    rest_rho = longint'(value);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    term_t t;
    int phase;
    bit [30:0] rho_values[5];
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tlast   = 1'b0;
    s_axis_tuser   = '0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    term_taken     = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_req       = 1'b0;
    hold_cnt       = 0;
    mismatches     = 0;
    terms_seen     = 0;
    accels_seen    = 0;
    idle_cycles    = 0;
    rest_rho       = longint'(RestReset);
    sum_x          = 0;
    sum_y          = 0;
    rho_values     = '{31'h7fff_ffff, 31'd0, 31'd1, 31'd65536, 31'd65536000};
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with the reset value of the register.
    pending_terms.push_back(empty_term(1'b1));             // particle with no neighbors
    t = random_term(1'b1);
    t.solid = 1'b0; t.self_p = 32'h0001_0000; t.self_rho = 31'h0001_0000;
    t.nbr_p = 32'hffff_0000; t.nbr_rho = 31'h0002_0000; t.nbr_vol = 31'd655;
    t.grad_x = 32'h0001_0000; t.grad_y = 32'hffff_8000;
    pending_terms.push_back(t);
    t.solid = 1'b1;
    pending_terms.push_back(t);
    t.self_rho = 31'h0; t.nbr_rho = 31'h0; t.solid = 1'b0;  // zero density
    pending_terms.push_back(t);
    t.self_p = 32'h7fff_ffff; t.self_rho = 31'd1; t.last = 1'b0;   // positive saturation
    pending_terms.push_back(t);
    t.self_p = 32'h8000_0000; t.nbr_p = 32'h8000_0000; t.nbr_rho = 31'd1;
    pending_terms.push_back(t);                            // negative saturation
    pending_terms.push_back(empty_term(1'b0));
    t.nbr_vol = 31'h7fff_ffff; t.grad_x = 32'h7fff_ffff; t.grad_y = 32'h8000_0000;
    for (int i = 0; i < 6; i++) pending_terms.push_back(t);  // drive the sums to the rails
    t.last = 1'b1;
    pending_terms.push_back(t);
    t.self_p = 32'hffff_ffff; t.nbr_p = 32'h0; t.self_rho = 31'h7fff_ffff;
    t.nbr_rho = 31'h7fff_ffff; t.nbr_vol = 31'h0; t.grad_x = 32'h0; t.grad_y = 32'hffff_ffff;
    pending_terms.push_back(t);
    for (int i = 0; i < 6; i++) pending_terms.push_back(random_term(1'(i % 2)));
    drain();

    // Random part, one register setting and idling mix per phase.
    for (phase = 0; phase < 10; phase++) begin
      write_rest_density(phase < 5 ? rho_values[phase] : 31'($urandom));
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (phase == 0 || phase == 6) hold_req = 1'b1;
      queue_particles(NumRandom / 10);
      drain();
    end

    $display("%0d terms accepted and %0d accelerations checked", terms_seen, accels_seen);
    $display("register settings: extremes, unity, default and random; mixed idle and hold-off");
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
